// ----- sv/dle_pkg.sv -----
// Shared types and constants for the dense layer engine.
`default_nettype none
package dle_pkg;

	localparam int INPUT_DEPTH  = 8192;
	localparam int HIDDEN_DEPTH = 512;
	localparam int ACC_WIDTH    = 48;

	localparam int IN_AW   = $clog2(INPUT_DEPTH);
	localparam int HID_AW  = $clog2(HIDDEN_DEPTH);
	localparam int POS_W   = 14;
	localparam int HLEN_W  = 10;
	localparam int NC_W    = 10;
	localparam int LAYER_W = 2;
	localparam int PROD_W  = 32;
	localparam int FRAC_SH = 14;

	localparam logic [POS_W-1:0]   POS_MAX            = '1;
	localparam logic [POS_W-1:0]   INPUT_LEN_RESET    = POS_W'(7680);
	localparam logic [HLEN_W-1:0]  HIDDEN_LEN_RESET   = HLEN_W'(512);
	localparam logic [LAYER_W-1:0] FINAL_LAYER_RESET  = LAYER_W'(2);

	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_WEIGHT = 2'd1,
		MODE_FINISH = 2'd2,
		MODE_NEXT   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_INPUT_LEN   = 2'd0,
		CFG_HIDDEN_LEN  = 2'd1,
		CFG_FINAL_LAYER = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_INPUT  = 2'd0,
		ACT_BANK_A = 2'd1,
		ACT_BANK_B = 2'd2
	} act_sel_t;

	// Per-request control that travels down the pipeline.
	typedef struct packed {
		mode_t                mode;
		logic signed [15:0]   value;
		logic                 in_range;
		act_sel_t             act_sel;
		logic                 relu_en;
		logic                 store_en;
		logic                 bank_b;
		logic [HID_AW-1:0]    waddr;
		logic [8:0]           nidx;
		logic [LAYER_W-1:0]   layer;
		logic                 err;
	} ctl_t;

endpackage
`default_nettype wire

// ----- sv/dense_layer_relu_engine.sv -----
// Top level of the fixed-point dense layer engine with ReLU.
//
// channel  direction  handshake          payload
// s_*      in         s_tvalid/s_tready  s_tdata value, s_tuser mode
// m_*      out        m_tvalid/m_tready  m_tdata neuron value/index/layer, m_tuser error
// cfg_*    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One request per cycle unless held; a finished neuron is offered after its bias request
// runs through activation read, product, accumulate, then round and saturate.
// After a layer change, requests hold until the last neuron of the previous layer is
// written into the hidden bank the new layer reads.
// The pipeline holds only while a finished neuron waits on a full output register.
// Reset clears counters and pipeline valids; activation stores need no clearing.
`default_nettype none
module dense_layer_relu_engine
	import dle_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] value
	input  wire logic [1:0]  s_tuser,   // [1:0] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [15:0] neuron_value, [24:16] neuron_index,
	                                    // [26:25] layer_index, [31:27] zero
	output logic [0:0]       m_tuser,   // [0] length_error
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [13:0] cfg_data
);

	logic [POS_W-1:0]   input_len_q;
	logic [HLEN_W-1:0]  hidden_len_q;
	logic [LAYER_W-1:0] final_layer_q;

	logic [POS_W-1:0]   wpos_q;
	logic [POS_W-1:0]   lpos_q;
	logic [NC_W-1:0]    nc_q;
	logic [LAYER_W-1:0] layer_q;

	logic [15:0] input_mem  [INPUT_DEPTH];
	logic [15:0] bank_a_mem [HIDDEN_DEPTH];
	logic [15:0] bank_b_mem [HIDDEN_DEPTH];
	logic [15:0] in_rd_q;
	logic [15:0] a_rd_q;
	logic [15:0] b_rd_q;

	mode_t              in_mode;
	logic               accept;
	logic               adv;
	logic               hazard;
	logic [POS_W-1:0]   exp_len;
	logic [POS_W-1:0]   load_lim;
	logic [POS_W-1:0]   lpos_inc;
	ctl_t               ctl_in;

	logic               valid_s1;
	ctl_t               ctl_s1;
	logic signed [15:0] act_s1;
	logic               valid_s2;
	ctl_t               ctl_s2;
	logic               valid_s3;
	ctl_t               ctl_s3;
	logic signed [ACC_WIDTH-1:0] sum_s3;

	logic signed [ACC_WIDTH-1:0] relu_sum;
	logic signed [ACC_WIDTH:0]   rnd_sum;
	logic [ACC_WIDTH-FRAC_SH:0]  q_wide;
	logic [15:0]                 q_sat;
	logic                        fin_s3;

	logic        out_valid_q;
	logic [15:0] out_value_q;
	logic [8:0]  out_nidx_q;
	logic [1:0]  out_layer_q;
	logic        out_err_q;

	assign in_mode   = mode_t'(s_tuser);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_len_q   <= INPUT_LEN_RESET;
			hidden_len_q  <= HIDDEN_LEN_RESET;
			final_layer_q <= FINAL_LAYER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_INPUT_LEN:   input_len_q   <= cfg_data[POS_W-1:0];
				CFG_HIDDEN_LEN:  hidden_len_q  <= cfg_data[HLEN_W-1:0];
				CFG_FINAL_LAYER: final_layer_q <= cfg_data[LAYER_W-1:0];
				default: ;
			endcase
		end
	end

	// expected weight count, capped at the depth of the store it reads
	always_comb begin
		if (32'(input_len_q) < INPUT_DEPTH) begin
			load_lim = input_len_q;
		end else begin
			load_lim = POS_W'(INPUT_DEPTH);
		end
		if (layer_q == '0) begin
			exp_len = load_lim;
		end else if (32'(hidden_len_q) < HIDDEN_DEPTH) begin
			exp_len = POS_W'(hidden_len_q);
		end else begin
			exp_len = POS_W'(HIDDEN_DEPTH);
		end
		lpos_inc = lpos_q + POS_W'(1);
	end

	// hold while a pending neuron still has to land in the bank the new layer reads
	always_comb begin
		hazard = 1'b0;
		if (layer_q != '0) begin
			if (valid_s1 && ctl_s1.mode == MODE_FINISH && ctl_s1.store_en
				&& ctl_s1.bank_b == !layer_q[0]) begin
				hazard = 1'b1;
			end
			if (valid_s2 && ctl_s2.mode == MODE_FINISH && ctl_s2.store_en
				&& ctl_s2.bank_b == !layer_q[0]) begin
				hazard = 1'b1;
			end
			if (valid_s3 && ctl_s3.mode == MODE_FINISH && ctl_s3.store_en
				&& ctl_s3.bank_b == !layer_q[0]) begin
				hazard = 1'b1;
			end
		end
	end

	assign fin_s3   = valid_s3 && ctl_s3.mode == MODE_FINISH;
	assign adv      = !(fin_s3 && out_valid_q && !m_tready);
	assign s_tready = adv && !hazard;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		ctl_in          = '0;
		ctl_in.mode     = in_mode;
		ctl_in.value    = s_tdata;
		ctl_in.in_range = wpos_q < exp_len;
		ctl_in.relu_en  = layer_q != final_layer_q;
		ctl_in.store_en = 32'(nc_q) < HIDDEN_DEPTH;
		ctl_in.bank_b   = layer_q[0];
		ctl_in.waddr    = HID_AW'(nc_q);
		ctl_in.nidx     = nc_q[8:0];
		ctl_in.layer    = layer_q;
		ctl_in.err      = wpos_q != exp_len;
		if (layer_q == '0) begin
			ctl_in.act_sel = ACT_INPUT;
		end else if (layer_q[0]) begin
			ctl_in.act_sel = ACT_BANK_A;
		end else begin
			ctl_in.act_sel = ACT_BANK_B;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q  <= '0;
			lpos_q  <= '0;
			nc_q    <= '0;
			layer_q <= '0;
		end else if (accept) begin
			case (in_mode)
				MODE_LOAD: begin
					if (lpos_inc >= load_lim) begin
						lpos_q <= '0;
					end else begin
						lpos_q <= lpos_inc;
					end
				end
				MODE_WEIGHT: begin
					if (wpos_q != POS_MAX) begin
						wpos_q <= wpos_q + POS_W'(1);
					end
				end
				MODE_FINISH: begin
					wpos_q <= '0;
					nc_q   <= nc_q + NC_W'(1);
				end
				MODE_NEXT: begin
					wpos_q <= '0;
					nc_q   <= '0;
					if (layer_q >= final_layer_q) begin
						layer_q <= '0;
						lpos_q  <= '0;
					end else begin
						layer_q <= layer_q + LAYER_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_mode == MODE_LOAD) begin
			input_mem[IN_AW'(lpos_q)] <= s_tdata;
		end
		if (accept && in_mode == MODE_WEIGHT) begin
			in_rd_q <= input_mem[IN_AW'(wpos_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fin_s3 && ctl_s3.store_en && !ctl_s3.bank_b) begin
			bank_a_mem[ctl_s3.waddr] <= q_sat;
		end
		if (accept && in_mode == MODE_WEIGHT) begin
			a_rd_q <= bank_a_mem[HID_AW'(wpos_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fin_s3 && ctl_s3.store_en && ctl_s3.bank_b) begin
			bank_b_mem[ctl_s3.waddr] <= q_sat;
		end
		if (accept && in_mode == MODE_WEIGHT) begin
			b_rd_q <= bank_b_mem[HID_AW'(wpos_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_comb begin
		case (ctl_s1.act_sel)
			ACT_INPUT:  act_s1 = in_rd_q;
			ACT_BANK_A: act_s1 = a_rd_q;
			ACT_BANK_B: act_s1 = b_rd_q;
			default:    act_s1 = '0;
		endcase
	end

	dle_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.ctl_s1   (ctl_s1),
		.act_s1   (act_s1),
		.valid_s2 (valid_s2),
		.ctl_s2   (ctl_s2),
		.valid_s3 (valid_s3),
		.ctl_s3   (ctl_s3),
		.sum_s3   (sum_s3)
	);

	// ReLU on all but the final layer, round half up to Q8.8, saturate
	always_comb begin
		if (ctl_s3.relu_en && sum_s3[ACC_WIDTH-1]) begin
			relu_sum = '0;
		end else begin
			relu_sum = sum_s3;
		end
		rnd_sum = {relu_sum[ACC_WIDTH-1], relu_sum} + (ACC_WIDTH+1)'(1 << (FRAC_SH-1));
		q_wide  = rnd_sum[ACC_WIDTH:FRAC_SH];
		if (!q_wide[ACC_WIDTH-FRAC_SH] && (|q_wide[ACC_WIDTH-FRAC_SH-1:15])) begin
			q_sat = 16'h7FFF;
		end else if (q_wide[ACC_WIDTH-FRAC_SH] && !(&q_wide[ACC_WIDTH-FRAC_SH-1:15])) begin
			q_sat = 16'h8000;
		end else begin
			q_sat = q_wide[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && fin_s3) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fin_s3) begin
			out_value_q <= q_sat;
			out_nidx_q  <= ctl_s3.nidx;
			out_layer_q <= ctl_s3.layer;
			out_err_q   <= ctl_s3.err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_layer_q, out_nidx_q, out_value_q};
	assign m_tuser  = out_err_q;

endmodule
`default_nettype wire

// ----- sv/dle_mac.sv -----
// Multiply and accumulate stages: product register, accumulator, finished sum.
`default_nettype none
module dle_mac
	import dle_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire logic                        valid_s1,
	input  wire ctl_t                        ctl_s1,
	input  wire logic signed [15:0]          act_s1,
	output logic                             valid_s2,
	output ctl_t                             ctl_s2,
	output logic                             valid_s3,
	output ctl_t                             ctl_s3,
	output logic signed [ACC_WIDTH-1:0]      sum_s3
);

	logic signed [PROD_W-1:0]    prod;
	logic signed [PROD_W-1:0]    prod_s2;
	logic signed [ACC_WIDTH-1:0] acc_q;
	logic signed [ACC_WIDTH-1:0] acc_sum;

	always_comb begin
		prod = '0;
		case (ctl_s1.mode)
			MODE_WEIGHT: begin
				if (ctl_s1.in_range) begin
					prod = act_s1 * ctl_s1.value;
				end
			end
			MODE_FINISH: begin
				// bias in Q8.8 lines up with Q10.22 products after a 14-bit shift
				prod = {{(PROD_W-16-FRAC_SH){ctl_s1.value[15]}}, ctl_s1.value,
					{FRAC_SH{1'b0}}};
			end
			default: begin
				prod = '0;
			end
		endcase
	end

	assign acc_sum = acc_q + {{(ACC_WIDTH-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			acc_q    <= '0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (valid_s2) begin
				case (ctl_s2.mode)
					MODE_WEIGHT: acc_q <= acc_sum;
					MODE_FINISH: acc_q <= '0;
					MODE_NEXT:   acc_q <= '0;
					default:     acc_q <= acc_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2  <= ctl_s1;
			prod_s2 <= prod;
			ctl_s3  <= ctl_s2;
			sum_s3  <= acc_sum;
		end
	end

endmodule
`default_nettype wire
